FILE: sv/rpip_pkg.sv
package rpip_pkg;

	typedef enum logic [4:0] {
		PH_IDLE   = 5'b00001,
		PH_FIRST  = 5'b00010,
		PH_AFTER0 = 5'b00100,
		PH_LEAD   = 5'b01000,
		PH_DIGITS = 5'b10000
	} phase_t;

	typedef enum logic [1:0] {
		RC_BIN = 2'd0,
		RC_OCT = 2'd1,
		RC_DEC = 2'd2,
		RC_HEX = 2'd3
	} radix_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LB    = 8'h62;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_LX    = 8'h78;

	localparam logic [31:0] SIGNED_MAG_MAX = 32'h8000_0000;

	typedef struct packed {
		phase_t      phase;
		radix_t      radix;
		logic [31:0] acc;
		logic        neg;
		logic        sgn;
	} parse_state_t;

	typedef struct packed {
		logic        emit;
		logic [31:0] value;
		logic        parse_error;
		radix_t      radix_code;
	} parse_result_t;

endpackage

FILE: sv/rpip_step.sv
module rpip_step (
	input  logic [7:0]            char_code,
	input  logic                  token_start,
	input  logic                  mode,
	input  rpip_pkg::parse_state_t cur,
	output rpip_pkg::parse_state_t nxt,
	output rpip_pkg::parse_result_t res
);
	import rpip_pkg::*;

	// {valid, digit value}
	function automatic logic [4:0] digit_decode(input logic [7:0] c, input radix_t rad);
		logic [7:0] diff;
		logic       ok;
		logic [3:0] d;
		begin
			diff = c - CH_ZERO;
			ok   = 1'b0;
			d    = 4'd0;
			if (c >= CH_ZERO && c <= CH_NINE) begin
				d = diff[3:0];
				case (rad)
					RC_BIN:  ok = (d < 4'd2);
					RC_OCT:  ok = (d < 4'd8);
					default: ok = 1'b1;
				endcase
			end else if (rad == RC_HEX && c >= CH_UA && c <= CH_UF) begin
				diff = c - CH_UA;
				d    = diff[3:0] + 4'd10;
				ok   = 1'b1;
			end else if (rad == RC_HEX && c >= CH_LA && c <= CH_LF) begin
				diff = c - CH_LA;
				d    = diff[3:0] + 4'd10;
				ok   = 1'b1;
			end
			return {ok, d};
		end
	endfunction

	phase_t      eff;
	logic        done;
	logic        bad;
	logic        fin;
	logic        ovf;
	logic [4:0]  dig;
	logic [31:0] scaled;

	always_comb begin
		nxt    = cur;
		res    = '0;
		eff    = cur.phase;
		done   = 1'b0;
		bad    = 1'b0;
		fin    = 1'b0;
		ovf    = 1'b0;
		dig    = '0;
		scaled = '0;

		if (token_start) begin
			nxt.sgn   = mode;
			nxt.neg   = 1'b0;
			nxt.acc   = '0;
			nxt.radix = RC_BIN;
			nxt.phase = PH_FIRST;
			eff       = PH_FIRST;
			if (mode && char_code == CH_MINUS) begin
				nxt.neg = 1'b1;
				done    = 1'b1;
			end
		end else if (cur.phase == PH_IDLE) begin
			done = 1'b1;
		end

		// prefix detection
		if (!done) begin
			unique case (eff)
				PH_FIRST: begin
					if (char_code == CH_ZERO) begin
						nxt.phase = PH_AFTER0;
						done      = 1'b1;
					end else begin
						nxt.radix = RC_DEC;
						eff       = PH_LEAD;
					end
				end
				PH_AFTER0: begin
					if (char_code == CH_LX || char_code == CH_UX) begin
						nxt.radix = RC_HEX;
						nxt.phase = PH_LEAD;
						done      = 1'b1;
					end else if (char_code == CH_LB) begin
						nxt.radix = RC_BIN;
						nxt.phase = PH_LEAD;
						done      = 1'b1;
					end else begin
						nxt.radix = RC_OCT;
						eff       = PH_LEAD;
					end
				end
				default: ;
			endcase
		end

		if (!done) begin
			if (eff == PH_LEAD) begin
				bad = (char_code == CH_NUL || char_code == CH_ZERO);
			end else begin
				fin = (char_code == CH_NUL || char_code == CH_SPACE);
			end
			dig = digit_decode(char_code, nxt.radix);
			case (nxt.radix)
				RC_BIN:  scaled = {nxt.acc[30:0], 1'b0};
				RC_OCT:  scaled = {nxt.acc[28:0], 3'b000};
				RC_DEC:  scaled = {nxt.acc[28:0], 3'b000} + {nxt.acc[30:0], 1'b0};
				default: scaled = {nxt.acc[27:0], 4'b0000};
			endcase
			if (!bad && !fin) begin
				if (!dig[4]) begin
					bad = 1'b1;
				end else begin
					nxt.acc   = scaled + {28'd0, dig[3:0]};
					nxt.phase = PH_DIGITS;
				end
			end
		end

		ovf = nxt.sgn && (nxt.acc > SIGNED_MAG_MAX);
		if (bad || fin) begin
			res.emit        = 1'b1;
			res.radix_code  = nxt.radix;
			res.parse_error = bad || ovf;
			if (bad || ovf) begin
				res.value = '0;
			end else if (nxt.sgn && nxt.neg) begin
				res.value = 32'd0 - nxt.acc;
			end else begin
				res.value = nxt.acc;
			end
			nxt.phase = PH_IDLE;
		end
	end

endmodule

FILE: sv/radix_prefixed_integer_parser_unit.sv
// Radix-prefixed integer parser.
// Input stream: one ASCII character per transfer on s_axis. tuser[0] marks the
// first character of a token and tuser[1] selects signed mode for that token.
// A token may open with '-' (signed mode), then "0x"/"0X" for hex, "0b" for
// binary, '0' for octal, else decimal; NUL or space ends it.
// Output stream: one transfer per finished or failed token on m_axis, carrying
// the 32-bit value (0 on error), the error flag and the detected radix.
// Characters outside a token, and an unfinished token cut short by a new
// token start, produce no transfer.
// An accepted character is first held in the input register; its result, if
// it ends a token, is then written to the output register.
// Throughput: one character per cycle when not stalled; each character costs
// a multiply-by-radix (shifts, one add if decimal) and an add in step logic.
// Stall: while m_axis_tready is low and a result is pending, the input
// register holds one character and then s_axis_tready drops.
// Reset: clears the token state to idle and empties both registers.
module radix_prefixed_integer_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] char_code
	input  logic [1:0]  s_axis_tuser,  // [0] token_start, [1] mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [31:0] value
	output logic [2:0]  m_axis_tuser   // [0] parse_error, [2:1] radix_code
);
	import rpip_pkg::*;

	logic          valid_s1;
	logic [7:0]    char_s1;
	logic          start_s1;
	logic          mode_s1;
	parse_state_t  st_q;
	parse_state_t  st_nxt;
	parse_result_t step_res;
	logic          out_valid_q;
	logic [31:0]   out_value_q;
	logic          out_err_q;
	radix_t        out_radix_q;
	logic          out_free;
	logic          fire;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign fire          = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1  <= s_axis_tdata;
			start_s1 <= s_axis_tuser[0];
			mode_s1  <= s_axis_tuser[1];
		end
	end

	rpip_step u_step (
		.char_code   (char_s1),
		.token_start (start_s1),
		.mode        (mode_s1),
		.cur         (st_q),
		.nxt         (st_nxt),
		.res         (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{phase: PH_IDLE, radix: RC_BIN, acc: '0, neg: 1'b0, sgn: 1'b0};
		end else if (fire) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && step_res.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && step_res.emit) begin
			out_value_q <= step_res.value;
			out_err_q   <= step_res.parse_error;
			out_radix_q <= step_res.radix_code;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_value_q;
	assign m_axis_tuser  = {out_radix_q, out_err_q};

	a_err_zero : assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 32'd0)
		else $error("error result carries a nonzero value");

	a_emit_idle : assert property (@(posedge clk) disable iff (!arst_n)
		fire && step_res.emit |=> st_q.phase == PH_IDLE)
		else $error("token state not idle after a result");

	a_start_mode : assert property (@(posedge clk) disable iff (!arst_n)
		fire && start_s1 |=> st_q.sgn == $past(mode_s1))
		else $error("token start did not latch the mode");

	a_out_load : assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(fire))
		else $error("result register loaded without a step");

endmodule
